### hw/rtl/aes128_pkg.sv
// shared types, s-box and round helpers for the aes-128 encryption pipeline
package aes128_pkg;

  typedef logic [127:0] block_t;
  typedef logic [7:0]   rcon_t;

  localparam int NumRounds  = 10;
  localparam int FullRounds = 9;

  // forward s-box
  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte n of a block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input block_t b, input int n);
    return b[127 - 8*n -: 8];
  endfunction

  // round constant for round index 0..9
  function automatic rcon_t rcon(input int r);
    rcon_t v;
    v = 8'h01;
    for (int i = 0; i < 9; i++) begin
      if (i < r) v = xtime(v);
    end
    return v;
  endfunction

endpackage

### hw/rtl/aes128_block_encrypt_core.sv
// top level: eleven-stage aes-128 encryption pipeline with stream handshake
// One block enters per cycle while the pipeline advances, passing one register stage for
// the initial key addition and one for each of the ten rounds, each round carrying its own
// key-schedule step alongside the data. The whole pipeline advances whenever its last
// stage is empty or the result is being taken, so throughput is one block per cycle.
module aes128_block_encrypt_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,  // plain_high, plain_low, cipher_key_high, cipher_key_low
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // cipher_high, cipher_low
);

  localparam int N = aes128_pkg::NumRounds;

  logic                en;
  logic                v   [N+1];
  aes128_pkg::block_t  st  [N+1];
  aes128_pkg::block_t  ky  [N+1];
  aes128_pkg::block_t  pt;
  aes128_pkg::block_t  ck;

  // pipeline advances when the output stage is empty or its result is being taken
  assign en = !v[N] || m_axis_tready;
  assign s_axis_tready = en;

  assign pt = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
  assign ck = {s_axis_tdata[191:128], s_axis_tdata[255:192]};

  // initial add round key
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= pt ^ ck;
      ky[0] <= ck;
    end
  end

  // round stages
  for (genvar g = 0; g < N; g++) begin : g_round
    aes128_round #(
      .RoundIdx (g),
      .MixEn    (g < aes128_pkg::FullRounds)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v[g]),
      .in_state  (st[g]),
      .in_key    (ky[g]),
      .out_valid (v[g+1]),
      .out_state (st[g+1]),
      .out_key   (ky[g+1])
    );
  end

  assign m_axis_tvalid = v[N];
  assign m_axis_tdata  = {st[N][63:0], st[N][127:64]};

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed during stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |=> v[0] == $past(s_axis_tvalid))
    else $error("accepted beat lost");
`endif

endmodule

### hw/rtl/aes128_round.sv
// one registered aes round with its key-schedule step
module aes128_round #(
  parameter int RoundIdx = 0,
  parameter bit MixEn = 1'b1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  aes128_pkg::block_t  in_state,
  input  aes128_pkg::block_t  in_key,
  output logic                out_valid,
  output aes128_pkg::block_t  out_state,
  output aes128_pkg::block_t  out_key
);

  localparam aes128_pkg::rcon_t Rc = aes128_pkg::rcon(RoundIdx);

  logic [7:0] s  [16];
  logic [7:0] k  [16];
  logic [7:0] t  [16];
  logic [7:0] nk [16];
  logic [7:0] m  [16];
  aes128_pkg::block_t state_next;
  aes128_pkg::block_t key_next;

  // sub bytes, shift rows, and mix columns when MixEn is set
  always_comb begin
    for (int n = 0; n < 16; n++) begin
      s[n] = aes128_pkg::get_byte(in_state, n);
      k[n] = aes128_pkg::get_byte(in_key, n);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c*4+r] = aes128_pkg::sbox(s[((c + r) % 4)*4 + r]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (MixEn) begin
        logic [7:0] a0, a1, a2, a3, all;
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        m[c*4]   = a0 ^ all ^ aes128_pkg::xtime(a0 ^ a1);
        m[c*4+1] = a1 ^ all ^ aes128_pkg::xtime(a1 ^ a2);
        m[c*4+2] = a2 ^ all ^ aes128_pkg::xtime(a2 ^ a3);
        m[c*4+3] = a3 ^ all ^ aes128_pkg::xtime(a3 ^ a0);
      end else begin
        for (int r = 0; r < 4; r++) m[c*4+r] = t[c*4+r];
      end
    end
  end

  // key expansion step and add round key
  always_comb begin
    nk[0] = k[0] ^ aes128_pkg::sbox(k[13]) ^ Rc;
    nk[1] = k[1] ^ aes128_pkg::sbox(k[14]);
    nk[2] = k[2] ^ aes128_pkg::sbox(k[15]);
    nk[3] = k[3] ^ aes128_pkg::sbox(k[12]);
    for (int n = 4; n < 16; n++) nk[n] = k[n] ^ nk[n-4];
    for (int n = 0; n < 16; n++) begin
      key_next[127 - 8*n -: 8]   = nk[n];
      state_next[127 - 8*n -: 8] = m[n] ^ nk[n];
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_state <= state_next;
      out_key   <= key_next;
    end
  end

endmodule

### test/aes128_block_encrypt_core_test.sv
// stream testbench for the aes-128 block encryption pipeline
`timescale 1ns / 100ps

module aes128_block_encrypt_core_test;

  localparam int RandomBlocks = 1850;
  localparam int CycleLimit   = 400000;
  localparam int DrainCycles  = 30;

  typedef struct packed {
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [63:0] plain_low;
    logic [63:0] plain_high;
  } block_in_t;

  typedef struct packed {
    logic [63:0] cipher_low;
    logic [63:0] cipher_high;
  } block_out_t;

  typedef struct {
    block_in_t  beat;
    logic       known;
    block_out_t cipher;
  } vector_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata;   // plain_high, plain_low, cipher_key_high, cipher_key_low
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // cipher_high, cipher_low

  block_out_t pending_ciphers[$];
  vector_t    vectors[$];
  int         errors;
  int         cycles;
  logic       feed_done;
  logic       long_hold;

  aes128_block_encrypt_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // forward s-box lookup
  function automatic logic [7:0] sub_byte(input logic [7:0] a);
    logic [7:0] tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return tab[a];
  endfunction

  function automatic logic [7:0] gf_x2(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // full aes-128 encryption of one beat, state held as 16 bytes in column order
  function automatic block_out_t encrypt_block(input block_in_t b);
    logic [7:0] st [16];
    logic [7:0] rk [16];
    logic [7:0] tmp [16];
    logic [7:0] w [4];
    logic [7:0] rc;
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] pt, ky, ct;
    block_out_t res;
    pt = {b.plain_high, b.plain_low};
    ky = {b.key_high, b.key_low};
    for (int i = 0; i < 16; i++) begin
      st[i] = pt[127 - 8*i -: 8] ^ ky[127 - 8*i -: 8];
      rk[i] = ky[127 - 8*i -: 8];
    end
    rc = 8'h01;
    for (int rnd = 0; rnd < aes128_pkg::NumRounds; rnd++) begin
      // sub bytes and shift rows
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          tmp[c*4 + r] = sub_byte(st[((c + r) & 3)*4 + r]);
      st = tmp;
      // mix columns on all but the last round
      if (rnd < aes128_pkg::FullRounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[c*4]; a1 = st[c*4+1]; a2 = st[c*4+2]; a3 = st[c*4+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          st[c*4]   = a0 ^ all ^ gf_x2(a0 ^ a1);
          st[c*4+1] = a1 ^ all ^ gf_x2(a1 ^ a2);
          st[c*4+2] = a2 ^ all ^ gf_x2(a2 ^ a3);
          st[c*4+3] = a3 ^ all ^ gf_x2(a3 ^ a0);
        end
      end
      // key schedule step
      w[0] = sub_byte(rk[13]) ^ rc;
      w[1] = sub_byte(rk[14]);
      w[2] = sub_byte(rk[15]);
      w[3] = sub_byte(rk[12]);
      for (int r = 0; r < 4; r++) rk[r] ^= w[r];
      for (int c = 1; c < 4; c++)
        for (int r = 0; r < 4; r++) rk[c*4 + r] ^= rk[(c-1)*4 + r];
      rc = gf_x2(rc);
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    end
    for (int i = 0; i < 16; i++) ct[127 - 8*i -: 8] = st[i];
    res.cipher_high = ct[127:64];
    res.cipher_low  = ct[63:0];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic block_in_t rand_beat();
    block_in_t b;
    b.plain_high = rand64();
    b.plain_low  = rand64();
    b.key_high   = rand64();
    b.key_low    = rand64();
    // occasionally pin whole halves to extremes
    case ($urandom_range(0, 15))
      0: b.plain_high = '0;
      1: b.plain_low  = '1;
      2: b.key_high   = '1;
      3: b.key_low    = '0;
      default: ;
    endcase
    return b;
  endfunction

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  // directed vectors: known-answer rows carry the cipher, others go to the predictor
  task automatic add_vector(input logic [127:0] pt, input logic [127:0] ky,
                            input logic known, input logic [127:0] ct);
    vector_t v;
    v.beat.plain_high = pt[127:64];
    v.beat.plain_low  = pt[63:0];
    v.beat.key_high   = ky[127:64];
    v.beat.key_low    = ky[63:0];
    v.known = known;
    v.cipher.cipher_high = ct[127:64];
    v.cipher.cipher_low  = ct[63:0];
    vectors.push_back(v);
  endtask

  // sender
  initial begin
    block_in_t b;
    int gap;
    cycles = 0;
    errors = 0;
    feed_done = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    // fips-197 appendix c.1 and b
    add_vector(128'h00112233445566778899aabbccddeeff, 128'h000102030405060708090a0b0c0d0e0f,
               1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a);
    add_vector(128'h3243f6a8885a308d313198a2e0370734, 128'h2b7e151628aed2a6abf7158809cf4f3c,
               1'b1, 128'h3925841d02dc09fbdc118597196a0b32);
    // all-zero block and key
    add_vector('0, '0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
    add_vector('1, '1, 1'b0, '0);
    add_vector('0, '1, 1'b0, '0);
    add_vector('1, '0, 1'b0, '0);
    for (int i = 0; i < 8; i++)
      add_vector(128'h1 << (i * 17), 128'h80 << (i * 15), 1'b0, '0);
    add_vector({2{64'haaaa_aaaa_aaaa_aaaa}}, {2{64'h5555_5555_5555_5555}}, 1'b0, '0);
    add_vector({2{64'h5555_5555_5555_5555}}, {2{64'haaaa_aaaa_aaaa_aaaa}}, 1'b0, '0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int n = 0; n < vectors.size() + RandomBlocks; n++) begin
      if (n < vectors.size()) begin
        b = vectors[n].beat;
        pending_ciphers.push_back(vectors[n].known ? vectors[n].cipher : encrypt_block(b));
      end else begin
        b = rand_beat();
        pending_ciphers.push_back(encrypt_block(b));
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (n % 200 < 40) gap = 0;
      // idle between beats only when a gap was drawn
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= b;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
    end
    s_axis_tvalid <= 1'b0;
    feed_done = 1'b1;
  end

  // receiver, with one long hold-off that lets the pipeline fill and back up
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    long_hold = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (!long_hold && cycles > 2000) begin
        long_hold = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if ((cycles / 500) % 3 == 0) stall = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    block_out_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_ciphers.size() == 0) begin
        $display("%0t unexpected cipher %h", $time, got);
        errors++;
      end else begin
        want = pending_ciphers.pop_front();
        if (got.cipher_high !== want.cipher_high) begin
          $display("%0t cipher_high expected %h actual %h", $time, want.cipher_high,
                   got.cipher_high);
          errors++;
        end
        if (got.cipher_low !== want.cipher_low) begin
          $display("%0t cipher_low expected %h actual %h", $time, want.cipher_low,
                   got.cipher_low);
          errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (feed_done);
    while (pending_ciphers.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
hw/rtl/aes128_pkg.sv
hw/rtl/aes128_round.sv
hw/rtl/aes128_block_encrypt_core.sv
test/aes128_block_encrypt_core_test.sv
